>>> hw/rtl/sitda_pkg.sv
// Package for the signed integer to decimal ASCII converter.
// Holds the character codes, the divide-by-ten reciprocal and the digit store
// write type. It depends on nothing.
`default_nettype none

package sitda_pkg;

    localparam int unsigned NUM_W       = 32;
    localparam int unsigned DIGIT_W     = 4;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned STORE_DEPTH = 10;
    localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);

    localparam logic [CHAR_W-1:0] DIGIT_BASE = 8'd48;
    localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'd45;

    // floor(n * RECIP_TEN / 2**RECIP_SHIFT) equals n / 10 for every 32-bit n.
    localparam logic [NUM_W-1:0] RECIP_TEN   = 32'hCCCC_CCCD;
    localparam int unsigned      RECIP_SHIFT = 35;

    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   addr;
        logic [DIGIT_W-1:0] data;
    } store_wr_t;

endpackage

`default_nettype wire

>>> hw/rtl/sitda_div10.sv
// Shared divide-by-ten unit: a registered reciprocal multiply, then the
// quotient and remainder worked out combinationally from the registered product. Depends on sitda_pkg.
`default_nettype none

module sitda_div10 (
    input  wire logic                         clk,
    input  wire logic                         load,
    input  wire logic [sitda_pkg::NUM_W-1:0]   value,
    output logic      [sitda_pkg::NUM_W-1:0]   quotient,
    output logic      [sitda_pkg::DIGIT_W-1:0] remainder
);
    import sitda_pkg::*;

    logic [2*NUM_W-1:0] product_reg;
    logic [NUM_W-1:0]   value_reg;
    logic [2*NUM_W-1:0] prod_shifted;
    logic [NUM_W-1:0]   q_times_ten;
    logic [NUM_W-1:0]   diff;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= {{NUM_W{1'b0}}, value} * {{NUM_W{1'b0}}, RECIP_TEN};
            value_reg   <= value;
        end
    end

    always_comb
    begin
        prod_shifted = product_reg >> RECIP_SHIFT;
        quotient     = prod_shifted[NUM_W-1:0];
        q_times_ten  = (quotient << 3) + (quotient << 1);
        diff         = value_reg - q_times_ten;
        remainder    = diff[DIGIT_W-1:0];
    end

endmodule

`default_nettype wire

>>> hw/rtl/sitda_digit_store.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Width and depth are parameters; it depends on nothing.
`default_nettype none

module sitda_digit_store #(
    parameter int unsigned DATA_W = 8,
    parameter int unsigned DEPTH  = 16,
    parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> hw/rtl/signed_int_to_decimal_ascii.sv
// Top level of the signed integer to decimal ASCII converter.
// Sequencer around sitda_div10 and sitda_digit_store; depends on sitda_pkg.
//
// A word is taken when start is high while busy is low. The magnitude is then
// divided by ten once per digit on the shared divide-by-ten unit (a registered
// reciprocal multiply, then the remainder step), and the text is sent out one
// character per cycle: a minus sign first for negative numbers, then the digits
// most significant first, the final one with last_char set. Each character is
// on ascii_char for exactly one cycle with strobe high, and the receiver cannot
// stall it. Busy stays high from the first divide step to the last digit read;
// the final character appears in the first cycle with busy low.
`default_nettype none

module signed_int_to_decimal_ascii (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic signed [sitda_pkg::NUM_W-1:0] num_value,
    output logic                                   strobe,
    output logic             [sitda_pkg::CHAR_W-1:0] ascii_char,
    output logic                                   last_char
);
    import sitda_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_REM   = 3'd2;
    localparam logic [2:0] S_SIGN  = 3'd3;
    localparam logic [2:0] S_DIGIT = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [NUM_W-1:0] work_reg, work_next;
    logic [IDX_W-1:0] count_reg, count_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             neg_reg, neg_next;

    logic              strobe_reg, strobe_next;
    logic              last_reg, last_next;
    logic              sign_reg, sign_next;

    logic [NUM_W-1:0]   raw;
    logic [NUM_W-1:0]   quotient;
    logic [DIGIT_W-1:0] remainder;
    logic [DIGIT_W-1:0] rd_data;
    logic [IDX_W-1:0]   rd_addr;
    logic               rd_en;
    logic               div_load;
    store_wr_t          wr;

    sitda_div10 u_div10 (
        .clk       (clk),
        .load      (div_load),
        .value     (work_reg),
        .quotient  (quotient),
        .remainder (remainder)
    );

    // The read is registered, so a digit addressed in S_DIGIT is on rd_data
    // in the following cycle, which is the cycle its strobe is high.
    sitda_digit_store #(
        .DATA_W (DIGIT_W),
        .DEPTH  (STORE_DEPTH),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign raw      = num_value;
    assign div_load = (state_reg == S_MUL);
    assign rd_en    = (state_reg == S_DIGIT);
    assign rd_addr  = idx_reg - 1'b1;

    always_comb
    begin
        state_next  = state_reg;
        work_next   = work_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        neg_next    = neg_reg;
        strobe_next = 1'b0;
        last_next   = 1'b0;
        sign_next   = 1'b0;
        wr.en       = 1'b0;
        wr.addr     = count_reg;
        wr.data     = remainder;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    neg_next   = raw[NUM_W-1];
                    work_next  = raw[NUM_W-1] ? (~raw + 1'b1) : raw;
                    count_next = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                state_next = S_REM;
            end
            S_REM:
            begin
                wr.en      = 1'b1;
                work_next  = quotient;
                count_next = count_reg + 1'b1;
                if (quotient != '0)
                begin
                    state_next = S_MUL;
                end
                else
                begin
                    idx_next   = count_reg + 1'b1;
                    state_next = neg_reg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN:
            begin
                strobe_next = 1'b1;
                sign_next   = 1'b1;
                state_next  = S_DIGIT;
            end
            S_DIGIT:
            begin
                strobe_next = 1'b1;
                last_next   = (idx_reg == IDX_W'(1));
                idx_next    = idx_reg - 1'b1;
                if (idx_reg == IDX_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            work_reg   <= '0;
            count_reg  <= '0;
            idx_reg    <= '0;
            neg_reg    <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            work_reg   <= work_next;
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            neg_reg    <= neg_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sign_reg <= sign_next;
        last_reg <= last_next;
    end

    assign busy       = (state_reg != S_IDLE);
    assign strobe     = strobe_reg;
    assign ascii_char = sign_reg ? MINUS_CHAR
                                 : (DIGIT_BASE + {{(CHAR_W-DIGIT_W){1'b0}}, rd_data});
    assign last_char  = last_reg;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for signed_int_to_decimal_ascii.
// Drives directed and random numbers and checks every character word against
// its expected text, given literally or from a local model of the conversion; depends on sitda_pkg and the block only.
`timescale 1ns / 100ps

module tb_top;

    import sitda_pkg::*;

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } char_word_t;

    localparam int DIRECTED_ROWS = 20;
    localparam int RANDOM_ITEMS  = 450;
    localparam int DRAIN_CYCLES  = 40;

    logic                    clk;
    logic                    rst_n;
    logic                    start;
    logic                    busy;
    logic signed [NUM_W-1:0] num_value;
    logic                    strobe;
    logic [CHAR_W-1:0]       ascii_char;
    logic                    last_char;

    char_word_t        expected_chars[$];
    int                error_count;

    logic [NUM_W-1:0]  dir_value [DIRECTED_ROWS];
    string             dir_text  [DIRECTED_ROWS];

    signed_int_to_decimal_ascii DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .num_value  (num_value),
        .strobe     (strobe),
        .ascii_char (ascii_char),
        .last_char  (last_char)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("tb_top: FAIL");
        $finish;
    end

    // Expected text of one number: the magnitude is split into digits least
    // significant first, then sent out in the opposite order.
    function automatic void queue_prediction(input logic [NUM_W-1:0] raw);
        logic               negative;
        logic [NUM_W-1:0]   mag;
        logic [DIGIT_W-1:0] digits [STORE_DEPTH];
        int                 count;
        char_word_t         w;
        negative = raw[NUM_W-1];
        mag      = negative ? (~raw + 1'b1) : raw;
        count    = 0;
        do
        begin
            if (count < STORE_DEPTH)
            begin
                digits[count] = DIGIT_W'(mag % 10);
                count++;
            end
            mag = mag / 10;
        end
        while (mag != 0);
        if (negative)
        begin
            w.code = MINUS_CHAR;
            w.last = 1'b0;
            expected_chars.push_back(w);
        end
        for (int i = count - 1; i >= 0; i--)
        begin
            w.code = DIGIT_BASE + CHAR_W'(digits[i]);
            w.last = (i == 0);
            expected_chars.push_back(w);
        end
    endfunction

    function automatic void queue_literal(input string text);
        char_word_t w;
        for (int i = 0; i < text.len(); i++)
        begin
            w.code = text[i];
            w.last = (i == text.len() - 1);
            expected_chars.push_back(w);
        end
    endfunction

    function automatic longint unsigned pow_ten(input int k);
        longint unsigned p;
        p = 1;
        for (int i = 0; i < k; i++)
            p = p * 10;
        return p;
    endfunction

    // Half numbers spread evenly over the digit counts, a quarter raw words and a
    // quarter values at or just below a power of ten.
    function automatic logic [NUM_W-1:0] random_number();
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned mag;
        longint unsigned cap;
        int              digits;
        bit              negative;
        negative = $urandom_range(0, 1);
        cap      = negative ? 64'd2147483648 : 64'd2147483647;
        case ($urandom_range(0, 3))
            0:
            begin
                return $urandom;
            end
            1:
            begin
                mag = pow_ten($urandom_range(0, 9)) - $urandom_range(0, 1);
            end
            default:
            begin
                digits = $urandom_range(1, 10);
                lo     = (digits == 1) ? 0 : pow_ten(digits - 1);
                hi     = pow_ten(digits) - 1;
                if (hi > cap)
                    hi = cap;
                mag = lo + (longint'({$urandom, $urandom}) % (hi - lo + 1));
            end
        endcase
        if (mag > cap)
            mag = cap;
        return negative ? (~mag[NUM_W-1:0] + 1'b1) : mag[NUM_W-1:0];
    endfunction

    // Called at a falling edge; returns at the falling edge after the word
    // has been taken.
    task automatic send_number(input logic [NUM_W-1:0] value, input int gap,
                               input string text);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        num_value <= value;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (text.len() != 0)
            queue_literal(text);
        else
            queue_prediction(value);
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        char_word_t w;
        if (rst_n && strobe)
        begin
            if (expected_chars.size() == 0)
            begin
                $display("%0t: unexpected word: char %0d last %0b",
                         $time, ascii_char, last_char);
                error_count++;
            end
            else
            begin
                w = expected_chars.pop_front();
                if (ascii_char !== w.code || last_char !== w.last)
                begin
                    $display("%0t: mismatch: expected char %0d last %0b, got char %0d last %0b",
                             $time, w.code, w.last, ascii_char, last_char);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        int gap;
        error_count = 0;
        rst_n       = 1'b0;
        start       = 1'b0;
        num_value   = '0;

        // An empty text means the row is checked against the local model.
        dir_value = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'hFFFF_FFF7,
                      32'd10, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
                      32'd1000000000, 32'd999999999, 32'hC465_3600,
                      32'd100, 32'd123456789, 32'hC521_974F, 32'h5555_5555,
                      32'hAAAA_AAAA, 32'd4294967196, 32'd65536, 32'd7};
        dir_text  = '{"0", "1", "-1", "9", "-9", "10", "2147483647",
                      "-2147483648", "-2147483647", "1000000000", "999999999",
                      "-1000000000", "100", "", "", "", "", "", "", ""};

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_number(dir_value[i], (i < 10) ? 0 : $urandom_range(0, 7), dir_text[i]);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Every fourth stretch runs back to back.
            gap = ((i / 50) % 4 == 3) ? 0 : $urandom_range(0, 7);
            send_number(random_number(), gap, "");
        end
        start <= 1'b0;

        while (expected_chars.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0 && expected_chars.size() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
